// ===== design/rsars_pkg.sv =====
package rsars_pkg;

    // default image limits
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // field and table widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int SUM_W      = 24;
    localparam int SQ_W       = 32;
    localparam int RUN_S_W    = 16;
    localparam int RUN_Q_W    = 24;
    localparam int CHANNELS   = 3;
    localparam int WORD_W     = CHANNELS * (SUM_W + SQ_W);
    localparam int SQ_BASE    = CHANNELS * SUM_W;
    localparam int AREA_W     = 17;
    localparam int PROD_W     = 49;
    localparam int TOTAL_W    = 51;
    localparam int SCORE_W    = 32;
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_W      = 32;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage

// ===== design/rgb_summed_area_region_stats.sv =====
// RGB summed-area region statistics. Load items (command 0) bring pixels in raster order and
// build per-channel prefix sums and prefix sums of squares in one shared table memory; a load
// passes through accept, read of the entry above and write. Query items (command 1) return
// area, floored channel means and the floored summed squared deviation of an inclusive
// rectangle. A valid query passes through the accept, the four corner reads through the
// single memory read port, the products on the one shared 32x24 multiplier, then the one
// radix-2 divider for the score and for each mean (skipped where the result saturates), and
// a final transfer. A flagged query goes from the accept straight to the final transfer.
// The block takes one item at a time; a finished result waits in the output register. Tables
// are undefined after reset and are read only where the current load has written them. A
// write to either register restarts loading.
module rgb_summed_area_region_stats #(
    parameter int MAX_WIDTH  = rsars_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsars_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsars_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rsars_pkg::APB_W-1:0]       pwdata,
    output logic [rsars_pkg::APB_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [rsars_pkg::PIX_W-1:0]       red,
    input  logic [rsars_pkg::PIX_W-1:0]       green,
    input  logic [rsars_pkg::PIX_W-1:0]       blue,
    input  logic [rsars_pkg::COORD_W-1:0]     left_col,
    input  logic [rsars_pkg::COORD_W-1:0]     top_row,
    input  logic [rsars_pkg::COORD_W-1:0]     right_col,
    input  logic [rsars_pkg::COORD_W-1:0]     bottom_row,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rsars_pkg::SCORE_W-1:0]     score,
    output logic [rsars_pkg::PIX_W-1:0]       avg_red,
    output logic [rsars_pkg::PIX_W-1:0]       avg_green,
    output logic [rsars_pkg::PIX_W-1:0]       avg_blue,
    output logic [rsars_pkg::AREA_W-1:0]      area,
    output logic                              bad_query
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int QW0   = (CW > RW) ? CW : RW;
    localparam int QW    = (QW0 > rsars_pkg::CFG_W) ? QW0 : rsars_pkg::CFG_W;
    localparam int FW    = 2 * QW + 14;
    localparam int SW    = rsars_pkg::SUM_W;
    localparam int QSW   = rsars_pkg::SQ_W;
    localparam int PW    = rsars_pkg::PIX_W;
    localparam int ARW   = rsars_pkg::AREA_W;
    localparam int TW    = rsars_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_RD,
        S_Q_MUL,
        S_Q_DIV_SET,
        S_Q_DIV_RUN,
        S_Q_FIN
    } state_t;

    state_t state_reg;

    // configuration and load position
    logic [rsars_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0]               load_col_reg;
    logic [RW-1:0]               load_row_reg;
    logic [rsars_pkg::RUN_S_W-1:0] run_s_reg [rsars_pkg::CHANNELS];
    logic [rsars_pkg::RUN_Q_W-1:0] run_q_reg [rsars_pkg::CHANNELS];

    // sequencer counters
    logic [2:0] qk_reg;
    logic [2:0] mj_reg;
    logic [1:0] div_idx_reg;
    logic [5:0] div_cnt_reg;

    // datapath registers
    logic [PW-1:0]                  pix_reg [rsars_pkg::CHANNELS];
    logic [rsars_pkg::COORD_W-1:0]  left_reg, top_reg, right_reg, bottom_reg;
    logic [ARW-1:0]                 area_reg;
    logic [SW-1:0]                  box_s_reg [rsars_pkg::CHANNELS];
    logic [QSW-1:0]                 box_q_reg [rsars_pkg::CHANNELS];
    logic [rsars_pkg::PROD_W-1:0]   prod_reg, a_term_reg;
    logic [TW-1:0]                  total_reg;
    logic [ARW-1:0]                 rem_reg;
    logic [31:0]                    low_reg;
    logic [rsars_pkg::SCORE_W-1:0]  res_score_reg;
    logic [PW-1:0]                  res_avg_reg [rsars_pkg::CHANNELS];
    logic                           res_bad_reg;
    logic                           out_valid_reg;
    logic [rsars_pkg::SCORE_W-1:0]  score_reg;
    logic [PW-1:0]                  avg_r_reg, avg_g_reg, avg_b_reg;
    logic [ARW-1:0]                 area_out_reg;
    logic                           bad_reg;

    // memory
    logic [rsars_pkg::WORD_W-1:0] mem [DEPTH];
    logic [rsars_pkg::WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]                mem_ra, mem_wa;
    logic [rsars_pkg::WORD_W-1:0] mem_wd;
    logic                         mem_we;

    function automatic logic [AW-1:0] cell_addr(input logic [QW-1:0] row,
                                                input logic [QW-1:0] col);
        logic [FW-1:0] full;
        full = FW'(row) * FW'(MAX_WIDTH) + FW'(col);
        return full[AW-1:0];
    endfunction

    function automatic logic [rsars_pkg::APB_W-1:0] APB_W_EXT(
        input logic [rsars_pkg::CFG_W-1:0] v);
        return rsars_pkg::APB_W'(v);
    endfunction

    // effective image size
    logic [QW-1:0] w_ext, h_ext, eff_w, eff_h;
    always_comb
    begin
        w_ext = QW'(width_reg);
        h_ext = QW'(height_reg);
        if (w_ext == '0)
            eff_w = QW'(1);
        else if (w_ext > QW'(MAX_WIDTH))
            eff_w = QW'(MAX_WIDTH);
        else
            eff_w = w_ext;
        if (h_ext == '0)
            eff_h = QW'(1);
        else if (h_ext > QW'(MAX_HEIGHT))
            eff_h = QW'(MAX_HEIGHT);
        else
            eff_h = h_ext;
    end

    // handshakes
    logic in_xfer, cfg_wr, is_load, load_ok, query_bad, row_end;
    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign is_load   = (command == rsars_pkg::CMD_LOAD);
    assign load_ok   = (QW'(load_row_reg) < eff_h) && (QW'(load_col_reg) < eff_w);
    assign query_bad = (QW'(load_row_reg) < eff_h) || (left_col > right_col) ||
                       (top_row > bottom_row) || (QW'(right_col) >= eff_w) ||
                       (QW'(bottom_row) >= eff_h);
    assign row_end   = (QW'(load_col_reg) + QW'(1)) >= eff_w;
    assign prdata    = (paddr[2] == rsars_pkg::REG_HEIGHT) ? APB_W_EXT(height_reg)
                                                          : APB_W_EXT(width_reg);

    // corner of the rectangle for the current read
    logic [QW-1:0] c_row, c_col;
    logic [1:0]    pk;
    logic          p_en, p_sub;
    always_comb
    begin
        case (qk_reg[1:0])
            2'd0:
            begin
                c_row = QW'(bottom_reg);
                c_col = QW'(right_reg);
            end
            2'd1:
            begin
                c_row = QW'(top_reg) - QW'(1);
                c_col = QW'(right_reg);
            end
            2'd2:
            begin
                c_row = QW'(bottom_reg);
                c_col = QW'(left_reg) - QW'(1);
            end
            default:
            begin
                c_row = QW'(top_reg) - QW'(1);
                c_col = QW'(left_reg) - QW'(1);
            end
        endcase
        pk = 2'(qk_reg - 3'd1);
        case (pk)
            2'd0:    begin p_en = 1'b1;                                   p_sub = 1'b0; end
            2'd1:    begin p_en = (top_reg != '0);                        p_sub = 1'b1; end
            2'd2:    begin p_en = (left_reg != '0);                       p_sub = 1'b1; end
            default: begin p_en = (top_reg != '0) && (left_reg != '0);    p_sub = 1'b0; end
        endcase
    end

    // memory ports
    logic [SW-1:0]  above_s [rsars_pkg::CHANNELS];
    logic [QSW-1:0] above_q [rsars_pkg::CHANNELS];
    logic [rsars_pkg::RUN_S_W-1:0] new_rs [rsars_pkg::CHANNELS];
    logic [rsars_pkg::RUN_Q_W-1:0] new_rq [rsars_pkg::CHANNELS];
    always_comb
    begin
        mem_ra = cell_addr(c_row, c_col);
        if (state_reg == S_LD_RD)
            mem_ra = cell_addr(QW'(load_row_reg) - QW'(1), QW'(load_col_reg));
        mem_wa = cell_addr(QW'(load_row_reg), QW'(load_col_reg));
        mem_we = (state_reg == S_LD_WR);
        for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
        begin
            above_s[ch] = (load_row_reg != '0) ? rd_data_reg[ch*SW +: SW] : '0;
            above_q[ch] = (load_row_reg != '0) ? rd_data_reg[rsars_pkg::SQ_BASE + ch*QSW +: QSW]
                                               : '0;
            new_rs[ch]  = run_s_reg[ch] + rsars_pkg::RUN_S_W'(pix_reg[ch]);
            new_rq[ch]  = run_q_reg[ch] + rsars_pkg::RUN_Q_W'(pix_reg[ch] * pix_reg[ch]);
            mem_wd[ch*SW +: SW] = above_s[ch] + SW'(new_rs[ch]);
            mem_wd[rsars_pkg::SQ_BASE + ch*QSW +: QSW] = above_q[ch] + QSW'(new_rq[ch]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // shared channel select, multiplier operands and divider step
    logic [1:0]     sel_ch;
    logic [SW-1:0]  sel_s;
    logic [QSW-1:0] sel_q;
    logic [31:0]    mul_a;
    logic [23:0]    mul_b;
    logic [ARW:0]   div_t;
    logic           div_bit;
    always_comb
    begin
        if (state_reg == S_Q_MUL)
            sel_ch = (mj_reg < 3'd6) ? mj_reg[2:1] : 2'd0;
        else
            sel_ch = (div_idx_reg != 2'd0) ? div_idx_reg - 2'd1 : 2'd0;
        sel_s   = box_s_reg[sel_ch];
        sel_q   = box_q_reg[sel_ch];
        mul_a   = mj_reg[0] ? 32'(sel_s) : sel_q;
        mul_b   = mj_reg[0] ? sel_s : 24'(area_reg);
        div_t   = {rem_reg, low_reg[31]};
        div_bit = (div_t >= {1'b0, area_reg});
    end

    // sequencer, configuration and load position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= rsars_pkg::CFG_W'(256);
            height_reg    <= rsars_pkg::CFG_W'(256);
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
            begin
                run_s_reg[ch] <= '0;
                run_q_reg[ch] <= '0;
            end
            qk_reg        <= '0;
            mj_reg        <= '0;
            div_idx_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_Q_FIN))
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (paddr[2] == rsars_pkg::REG_WIDTH)
                    width_reg <= pwdata[rsars_pkg::CFG_W-1:0];
                else
                    height_reg <= pwdata[rsars_pkg::CFG_W-1:0];
                load_col_reg <= '0;
                load_row_reg <= '0;
                for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
                begin
                    run_s_reg[ch] <= '0;
                    run_q_reg[ch] <= '0;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        qk_reg <= '0;
                        if (is_load)
                            state_reg <= load_ok ? S_LD_RD : S_IDLE;
                        else
                            state_reg <= query_bad ? S_Q_FIN : S_Q_RD;
                    end
                end
                S_LD_RD:
                    state_reg <= S_LD_WR;
                S_LD_WR:
                begin
                    if (row_end)
                    begin
                        load_col_reg <= '0;
                        load_row_reg <= load_row_reg + RW'(1);
                        for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
                        begin
                            run_s_reg[ch] <= '0;
                            run_q_reg[ch] <= '0;
                        end
                    end
                    else
                    begin
                        load_col_reg <= load_col_reg + CW'(1);
                        for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
                        begin
                            run_s_reg[ch] <= new_rs[ch];
                            run_q_reg[ch] <= new_rq[ch];
                        end
                    end
                    state_reg <= S_IDLE;
                end
                S_Q_RD:
                begin
                    qk_reg <= qk_reg + 3'd1;
                    if (qk_reg == 3'd4)
                    begin
                        mj_reg    <= '0;
                        state_reg <= S_Q_MUL;
                    end
                end
                S_Q_MUL:
                begin
                    mj_reg <= mj_reg + 3'd1;
                    if (mj_reg == 3'd6)
                    begin
                        div_idx_reg <= '0;
                        state_reg   <= S_Q_DIV_SET;
                    end
                end
                S_Q_DIV_SET:
                begin
                    div_cnt_reg <= (div_idx_reg == 2'd0) ? 6'd32 : 6'd8;
                    if (div_idx_reg == 2'd0)
                    begin
                        if (total_reg[TW-1:32] >= (TW-32)'(area_reg))
                            div_idx_reg <= div_idx_reg + 2'd1;
                        else
                            state_reg <= S_Q_DIV_RUN;
                    end
                    else if (ARW'(sel_s[SW-1:8]) >= area_reg)
                    begin
                        div_idx_reg <= div_idx_reg + 2'd1;
                        if (div_idx_reg == 2'd3)
                            state_reg <= S_Q_FIN;
                    end
                    else
                        state_reg <= S_Q_DIV_RUN;
                end
                S_Q_DIV_RUN:
                begin
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1)
                    begin
                        div_idx_reg <= div_idx_reg + 2'd1;
                        state_reg   <= (div_idx_reg == 2'd3) ? S_Q_FIN : S_Q_DIV_SET;
                    end
                end
                S_Q_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    pix_reg[0] <= red;
                    pix_reg[1] <= green;
                    pix_reg[2] <= blue;
                    left_reg   <= left_col;
                    top_reg    <= top_row;
                    right_reg  <= right_col;
                    bottom_reg <= bottom_row;
                    area_reg   <= (ARW'(right_col) - ARW'(left_col) + ARW'(1)) *
                                  (ARW'(bottom_row) - ARW'(top_row) + ARW'(1));
                    total_reg  <= '0;
                    res_bad_reg   <= query_bad;
                    res_score_reg <= '0;
                    for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
                    begin
                        box_s_reg[ch]   <= '0;
                        box_q_reg[ch]   <= '0;
                        res_avg_reg[ch] <= '0;
                    end
                end
            end
            S_Q_RD:
            begin
                // fold in the corner read on the previous cycle
                if (qk_reg != 3'd0 && p_en)
                begin
                    for (int ch = 0; ch < rsars_pkg::CHANNELS; ch++)
                    begin
                        if (p_sub)
                        begin
                            box_s_reg[ch] <= box_s_reg[ch] - rd_data_reg[ch*SW +: SW];
                            box_q_reg[ch] <= box_q_reg[ch] -
                                rd_data_reg[rsars_pkg::SQ_BASE + ch*QSW +: QSW];
                        end
                        else
                        begin
                            box_s_reg[ch] <= box_s_reg[ch] + rd_data_reg[ch*SW +: SW];
                            box_q_reg[ch] <= box_q_reg[ch] +
                                rd_data_reg[rsars_pkg::SQ_BASE + ch*QSW +: QSW];
                        end
                    end
                end
            end
            S_Q_MUL:
            begin
                // even steps: sumsq*area, odd steps: sum*sum
                prod_reg <= rsars_pkg::PROD_W'(mul_a * mul_b);
                if (mj_reg != 3'd0)
                begin
                    if (mj_reg[0])
                        a_term_reg <= prod_reg;
                    else if (a_term_reg > prod_reg)
                        total_reg <= total_reg + TW'(a_term_reg - prod_reg);
                end
            end
            S_Q_DIV_SET:
            begin
                if (div_idx_reg == 2'd0)
                begin
                    res_score_reg <= '1;
                    rem_reg <= total_reg[32 +: ARW];
                    low_reg <= total_reg[31:0];
                end
                else
                begin
                    res_avg_reg[sel_ch] <= '1;
                    rem_reg <= ARW'(sel_s[SW-1:8]);
                    low_reg <= {sel_s[7:0], 24'b0};
                end
            end
            S_Q_DIV_RUN:
            begin
                rem_reg <= div_bit ? ARW'(div_t - {1'b0, area_reg}) : div_t[ARW-1:0];
                low_reg <= {low_reg[30:0], div_bit};
                if (div_cnt_reg == 6'd1)
                begin
                    if (div_idx_reg == 2'd0)
                        res_score_reg <= {low_reg[30:0], div_bit};
                    else
                        res_avg_reg[sel_ch] <= {low_reg[6:0], div_bit};
                end
            end
            S_Q_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    score_reg    <= res_score_reg;
                    avg_r_reg    <= res_avg_reg[0];
                    avg_g_reg    <= res_avg_reg[1];
                    avg_b_reg    <= res_avg_reg[2];
                    area_out_reg <= res_bad_reg ? '0 : area_reg;
                    bad_reg      <= res_bad_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign avg_red   = avg_r_reg;
    assign avg_green = avg_g_reg;
    assign avg_blue  = avg_b_reg;
    assign area      = area_out_reg;
    assign bad_query = bad_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 100;
    localparam int TARGET_ITEMS = 1000;

    typedef struct {
        bit [31:0] score;
        bit [7:0]  avg [3];
        bit [16:0] area;
        bit        bad;
    } region_stats_t;

    // Mirror of the summed-area tables and the region statistics that follow from them
    class region_scoreboard;
        bit [23:0]     sum_tab [3][65536];
        bit [31:0]     sq_tab [3][65536];
        bit [8:0]      width_reg;
        bit [8:0]      height_reg;
        int unsigned   load_col;
        int unsigned   load_row;
        bit [15:0]     run_sum [3];
        bit [23:0]     run_sq [3];
        region_stats_t stats_q [$];
        int            errors;

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            restart();
        endfunction

        function void restart();
            load_col = 0;
            load_row = 0;
            for (int c = 0; c < 3; c++)
            begin
                run_sum[c] = '0;
                run_sq[c]  = '0;
            end
        endfunction

        function void set_reg(logic idx, bit [8:0] value);
            if (idx == rsars_pkg::REG_WIDTH)
                width_reg = value;
            else
                height_reg = value;
            restart();
        endfunction

        function int unsigned eff_w();
            return (width_reg == 0) ? 1 : (width_reg > 256) ? 256 : width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg == 0) ? 1 : (height_reg > 256) ? 256 : height_reg;
        endfunction

        function int pending();
            return stats_q.size();
        endfunction

        // modular rectangle sum from a prefix table (sq selects the squares table)
        function bit [31:0] box(int ch, bit sq, int unsigned t, int unsigned l,
                                int unsigned b, int unsigned r);
            bit [31:0] acc;
            acc = sq ? sq_tab[ch][b*256+r] : sum_tab[ch][b*256+r];
            if (t > 0)
                acc -= sq ? sq_tab[ch][(t-1)*256+r] : sum_tab[ch][(t-1)*256+r];
            if (l > 0)
                acc -= sq ? sq_tab[ch][b*256+l-1] : sum_tab[ch][b*256+l-1];
            if (t > 0 && l > 0)
                acc += sq ? sq_tab[ch][(t-1)*256+l-1] : sum_tab[ch][(t-1)*256+l-1];
            return sq ? acc : (acc & 32'hFF_FFFF);
        endfunction

        function void note_input(logic cmd, bit [7:0] pix [3], bit [7:0] l, bit [7:0] t,
                                 bit [7:0] r, bit [7:0] b);
            int unsigned   w;
            int unsigned   h;
            int unsigned   idx;
            bit [63:0]     ar;
            bit [63:0]     total;
            bit [63:0]     s;
            bit [63:0]     q;
            bit [63:0]     quot;
            region_stats_t res;
            w = eff_w();
            h = eff_h();
            if (cmd == rsars_pkg::CMD_LOAD)
            begin
                // loads past the end of the image are dropped
                if (load_row >= h || load_col >= w)
                    return;
                idx = load_row*256 + load_col;
                for (int c = 0; c < 3; c++)
                begin
                    run_sum[c] = run_sum[c] + pix[c];
                    run_sq[c]  = run_sq[c] + pix[c]*pix[c];
                    sum_tab[c][idx] = ((load_row > 0) ? sum_tab[c][idx-256] : 24'd0)
                                      + 24'(run_sum[c]);
                    sq_tab[c][idx]  = ((load_row > 0) ? sq_tab[c][idx-256] : 32'd0)
                                      + 32'(run_sq[c]);
                end
                if (load_col + 1 >= w)
                begin
                    load_col = 0;
                    load_row++;
                    for (int c = 0; c < 3; c++)
                    begin
                        run_sum[c] = '0;
                        run_sq[c]  = '0;
                    end
                end
                else
                    load_col++;
                return;
            end
            res.score = '0;
            res.area  = '0;
            res.bad   = 1'b1;
            for (int c = 0; c < 3; c++)
                res.avg[c] = '0;
            if (!(load_row < h || l > r || t > b || r >= w || b >= h))
            begin
                ar    = 64'(r - l + 1) * 64'(b - t + 1);
                total = '0;
                for (int c = 0; c < 3; c++)
                begin
                    s = box(c, 1'b0, t, l, b, r);
                    q = box(c, 1'b1, t, l, b, r);
                    if (q*ar > s*s)
                        total += q*ar - s*s;
                    quot = s / ar;
                    res.avg[c] = (quot > 255) ? 8'd255 : quot[7:0];
                end
                quot      = total / ar;
                res.score = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                res.area  = ar[16:0];
                res.bad   = 1'b0;
            end
            stats_q.push_back(res);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(region_stats_t got);
            region_stats_t want;
            if (stats_q.size() == 0)
            begin
                report_mismatch("unexpected result, score", got.score, 0);
                return;
            end
            want = stats_q.pop_front();
            if (got.score != want.score)
                report_mismatch("score", got.score, want.score);
            if (got.avg[0] != want.avg[0])
                report_mismatch("avg_red", got.avg[0], want.avg[0]);
            if (got.avg[1] != want.avg[1])
                report_mismatch("avg_green", got.avg[1], want.avg[1]);
            if (got.avg[2] != want.avg[2])
                report_mismatch("avg_blue", got.avg[2], want.avg[2]);
            if (got.area != want.area)
                report_mismatch("area", got.area, want.area);
            if (got.bad != want.bad)
                report_mismatch("bad_query", got.bad, want.bad);
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [rsars_pkg::CFG_ADDR_W-1:0] paddr;
    logic [rsars_pkg::APB_W-1:0]      pwdata;
    logic [rsars_pkg::APB_W-1:0]      prdata;
    logic                             pready;
    logic                             in_valid;
    logic                             in_ready;
    logic                             command;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic [7:0]                       left_col;
    logic [7:0]                       top_row;
    logic [7:0]                       right_col;
    logic [7:0]                       bottom_row;
    logic                             out_valid;
    logic                             out_ready;
    logic [rsars_pkg::SCORE_W-1:0]    score;
    logic [7:0]                       avg_red;
    logic [7:0]                       avg_green;
    logic [7:0]                       avg_blue;
    logic [rsars_pkg::AREA_W-1:0]     area;
    logic                             bad_query;

    region_scoreboard sb;
    int               items_sent;
    int               idle_cycles;
    int               stall_left;
    bit               no_idling;

    rgb_summed_area_region_stats dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (no_idling)
            return 0;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    endfunction

    // result side: random back-pressure and checking of each transfer
    always @(posedge clk)
    begin
        region_stats_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.score  = score;
            got.avg[0] = avg_red;
            got.avg[1] = avg_green;
            got.avg[2] = avg_blue;
            got.area   = area;
            got.bad    = bad_query;
            sb.check_result(got);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_left = gap_len();
            out_ready <= (stall_left == 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(logic cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                        bit [7:0] l, bit [7:0] t, bit [7:0] rc, bit [7:0] bt);
        int        gap;
        bit [7:0]  pix [3];
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        red        <= r;
        green      <= g;
        blue       <= b;
        left_col   <= l;
        top_row    <= t;
        right_col  <= rc;
        bottom_row <= bt;
        do
            @(posedge clk);
        while (!in_ready);
        pix[0] = r;
        pix[1] = g;
        pix[2] = b;
        sb.note_input(cmd, pix, l, t, rc, bt);
        items_sent++;
    endtask

    task automatic load_px(bit [7:0] r, bit [7:0] g, bit [7:0] b);
        send(rsars_pkg::CMD_LOAD, r, g, b, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
    endtask

    task automatic query(bit [7:0] l, bit [7:0] t, bit [7:0] r, bit [7:0] b);
        send(rsars_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), l, t, r, b);
    endtask

    task automatic load_random(int n);
        for (int i = 0; i < n; i++)
            load_px(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // query inside the current image, or anything at all
    task automatic query_random(bit wild);
        int unsigned w;
        int unsigned h;
        int unsigned l;
        int unsigned t;
        w = sb.eff_w();
        h = sb.eff_h();
        if (wild)
            query(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
        begin
            l = $urandom_range(0, w - 1);
            t = $urandom_range(0, h - 1);
            query(8'(l), 8'(t), 8'($urandom_range(l, w - 1)), 8'($urandom_range(t, h - 1)));
        end
    endtask

    // wait for the block to go quiet, then write both registers
    task automatic configure(bit [8:0] w, bit [8:0] h);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        for (int i = 0; i < 2; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (i == 0) ? {rsars_pkg::REG_WIDTH, 2'b00} : {rsars_pkg::REG_HEIGHT, 2'b00};
            pwdata  <= (i == 0) ? 32'(w) : 32'(h);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            sb.set_reg((i == 0) ? rsars_pkg::REG_WIDTH : rsars_pkg::REG_HEIGHT, (i == 0) ? w : h);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        sb          = new();
        items_sent  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        no_idling   = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        command     = rsars_pkg::CMD_LOAD;
        red         = '0;
        green       = '0;
        blue        = '0;
        left_col    = '0;
        top_row     = '0;
        right_col   = '0;
        bottom_row  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any load the image is incomplete
        query(0, 0, 0, 0);

        // single pixel image: corner-origin query and out-of-image bounds
        configure(9'd1, 9'd1);
        query(0, 0, 0, 0);
        load_px(255, 0, 255);
        load_px(1, 2, 3);
        query(0, 0, 0, 0);
        query(0, 0, 1, 0);
        query(0, 0, 0, 1);

        // width above range clamps to 256, height zero clamps to 1
        configure(9'd511, 9'd0);
        load_random(100);
        query(0, 0, 10, 0);
        load_random(156);
        query(0, 0, 255, 0);
        query(255, 0, 255, 0);
        query(5, 0, 4, 0);
        query(0, 0, 255, 1);

        // tall narrow image reaching the last row
        no_idling = 1'b1;
        configure(9'd2, 9'd256);
        for (int i = 0; i < 512; i++)
            load_px((i % 3 == 0) ? 8'd255 : 8'd0, 8'($urandom), (i % 2) ? 8'd255 : 8'd0);
        no_idling = 1'b0;
        query(0, 0, 1, 255);
        query(1, 255, 1, 255);
        query(0, 9, 1, 8);
        query(2, 0, 2, 0);
        query(0, 100, 1, 200);

        // random phases, each with its own image size
        while (items_sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: begin w = 256; h = $urandom_range(1, 2); end
                1: begin w = $urandom_range(1, 2); h = 256; end
                2: begin w = $urandom_range(257, 511); h = 1; end
                default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
            endcase
            no_idling = ($urandom_range(0, 4) == 0);
            configure(9'(w), 9'(h));
            w = sb.eff_w();
            h = sb.eff_h();
            for (int i = 0; i < w*h; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    query_random($urandom_range(0, 1) == 1);
                load_px(8'($urandom), 8'($urandom), 8'($urandom));
            end
            load_random($urandom_range(0, 2));
            repeat ($urandom_range(10, 30))
                query_random($urandom_range(0, 4) == 0);
        end

        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rsars_pkg.sv
design/rgb_summed_area_region_stats.sv
bench/testbench.sv
